// ----- hdl/npe_pkg.sv -----
// ----------------------------------------------------------------------------
// Next permutation engine package
// Shared widths, default capacity and codes for the engine and its RAM.
// ----------------------------------------------------------------------------
package npe_pkg;

    // Default number of elements the engine can hold.
    localparam int MAX_LEN_DEF = 16;

    // Width of one element.
    localparam int DATA_W = 16;

    // Input opcodes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    // Where an emitted element comes from.
    typedef enum logic [1:0] {
        SRC_MEM  = 2'd0,
        SRC_QVAL = 2'd1,
        SRC_PVAL = 2'd2
    } t_src;

endpackage

// ----- hdl/npe_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read; the read data
// holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module npe_ram #(
    parameter int WIDTH = npe_pkg::DATA_W,
    parameter int DEPTH = npe_pkg::MAX_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/next_permutation_engine.sv -----
// ----------------------------------------------------------------------------
// Next permutation engine
// Holds a sequence and steps it to its next lexicographic permutation.
// ----------------------------------------------------------------------------
// A load beat (opcode 0) appends one value; a load that follows a closed
// sequence starts a new one, and values past MAX_LEN are dropped. An advance
// beat (opcode 1) emits the whole next permutation as n beats with last set
// on the final one, or a single beat with status set when no next
// permutation exists. The sequence lives in two banks of RAM with one read
// port each: an advance scans the active bank from the right for the pivot
// p, scans again for its successor q, then reads the active bank once per
// element while writing the new permutation to the other bank, and the banks
// then swap. The engine takes no new input until the advance has handed out
// its last beat, output stalls included. A sequence shorter than two answers
// without a scan; a sequence without a next permutation answers after the
// full pivot scan. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module next_permutation_engine #(
    parameter int MAX_LEN = npe_pkg::MAX_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_opcode,
    input  logic [npe_pkg::DATA_W-1:0] i_value,
    input  logic                      i_final_element,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [npe_pkg::DATA_W-1:0] o_element,
    output logic                      o_last,
    output logic                      o_status
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = npe_pkg::DATA_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PIV  = 5'b00010,
        S_SUCC = 5'b00100,
        S_EMIT = 5'b01000,
        S_NONE = 5'b10000
    } t_state;

    // Control state.
    t_state          r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic            r_closed, n_closed;
    logic            r_bank, n_bank;
    logic            r_rv, n_rv;
    logic            r_go, n_go;
    logic            r_ovld, n_ovld;

    // Datapath registers.
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_raddr, n_raddr;
    logic [DW-1:0]   r_prev, n_prev;
    logic            r_hprev, n_hprev;
    logic [AW-1:0]   r_piv, n_piv;
    logic [DW-1:0]   r_pval, n_pval;
    logic [AW-1:0]   r_qidx, n_qidx;
    logic [DW-1:0]   r_qval, n_qval;
    npe_pkg::t_src   r_tsrc, n_tsrc;
    logic            r_tlast, n_tlast;
    logic [DW-1:0]   r_oel, n_oel;
    logic            r_olast, n_olast;
    logic            r_ostat, n_ostat;

    // RAM ports.
    logic            ld_we, em_we, rd_en;
    logic [AW-1:0]   ld_addr, rd_addr;
    logic [DW-1:0]   em_data;
    logic [DW-1:0]   rd0, rd1, rdata;
    logic            we0, we1;
    logic [AW-1:0]   waddr0, waddr1;
    logic [DW-1:0]   wdata0, wdata1;

    // Helpers.
    logic            in_fire, out_free, issue, move;
    logic [LW:0]     mirror;
    logic [AW-1:0]   src_addr;
    npe_pkg::t_src   src_kind;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_ovld || i_out_ready;
    assign rdata    = r_bank ? rd1 : rd0;

    // Source of element r_idx in the new permutation: prefix as is, the
    // successor value at the pivot, then the suffix mirrored with the old
    // pivot value dropped into the successor's place.
    assign mirror = (LW+1)'(r_len) + (LW+1)'(r_piv) - (LW+1)'(r_idx);
    always_comb begin
        src_addr = r_idx;
        src_kind = npe_pkg::SRC_MEM;
        if (r_idx == r_piv) begin
            src_kind = npe_pkg::SRC_QVAL;
        end else if (r_idx > r_piv) begin
            src_addr = mirror[AW-1:0];
            if (mirror[AW-1:0] == r_qidx) begin
                src_kind = npe_pkg::SRC_PVAL;
            end
        end
    end

    // Value of the beat now held in the read register.
    always_comb begin
        case (r_tsrc)
            npe_pkg::SRC_QVAL: em_data = r_qval;
            npe_pkg::SRC_PVAL: em_data = r_pval;
            default:           em_data = rdata;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_closed = r_closed;
        n_bank  = r_bank;
        n_rv    = r_rv;
        n_go    = r_go;
        n_idx   = r_idx;
        n_raddr = r_raddr;
        n_prev  = r_prev;
        n_hprev = r_hprev;
        n_piv   = r_piv;
        n_pval  = r_pval;
        n_qidx  = r_qidx;
        n_qval  = r_qval;
        n_tsrc  = r_tsrc;
        n_tlast = r_tlast;
        ld_we   = 1'b0;
        ld_addr = r_len[AW-1:0];
        em_we   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        issue   = 1'b0;
        move    = 1'b0;
        n_ovld  = r_ovld;
        n_oel   = r_oel;
        n_olast = r_olast;
        n_ostat = r_ostat;

        if (r_ovld && i_out_ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_opcode == npe_pkg::OP_LOAD) begin
                        n_closed = i_final_element;
                        if (r_closed) begin
                            ld_we   = 1'b1;
                            ld_addr = '0;
                            n_len   = LW'(1);
                        end else if (r_len < LW'(MAX_LEN)) begin
                            ld_we = 1'b1;
                            n_len = r_len + LW'(1);
                        end
                    end else if (r_len < LW'(2)) begin
                        n_state = S_NONE;
                    end else begin
                        n_state = S_PIV;
                        n_idx   = AW'(r_len - LW'(1));
                        n_go    = 1'b1;
                        n_rv    = 1'b0;
                        n_hprev = 1'b0;
                    end
                end
            end

            S_PIV: begin
                // Walk right to left looking for an ascent.
                issue = r_go;
                rd_en = issue;
                n_rv  = issue;
                if (issue) begin
                    n_raddr = r_idx;
                    n_idx   = r_idx - AW'(1);
                    n_go    = (r_idx != '0);
                end
                if (r_rv) begin
                    if (r_hprev && (rdata < r_prev)) begin
                        n_piv   = r_raddr;
                        n_pval  = rdata;
                        n_state = S_SUCC;
                        n_idx   = AW'(r_len - LW'(1));
                        n_go    = 1'b1;
                        n_rv    = 1'b0;
                    end else if (r_raddr == '0) begin
                        n_state = S_NONE;
                        n_rv    = 1'b0;
                        n_go    = 1'b0;
                    end else begin
                        n_prev  = rdata;
                        n_hprev = 1'b1;
                    end
                end
            end

            S_SUCC: begin
                // Rightmost element larger than the pivot.
                issue = r_go;
                rd_en = issue;
                n_rv  = issue;
                if (issue) begin
                    n_raddr = r_idx;
                    n_idx   = r_idx - AW'(1);
                    n_go    = (r_idx != '0);
                end
                if (r_rv && (rdata > r_pval)) begin
                    n_qidx  = r_raddr;
                    n_qval  = rdata;
                    n_state = S_EMIT;
                    n_idx   = '0;
                    n_go    = 1'b1;
                    n_rv    = 1'b0;
                end
            end

            S_EMIT: begin
                // The read register acts as a skid stage before the output.
                move  = r_rv && out_free;
                issue = r_go && (!r_rv || move);
                rd_en = issue;
                rd_addr = src_addr;
                n_rv  = issue || (r_rv && !move);
                if (issue) begin
                    n_raddr = r_idx;
                    n_tsrc  = src_kind;
                    n_tlast = (LW'(r_idx) == (r_len - LW'(1)));
                    n_idx   = r_idx + AW'(1);
                    n_go    = (LW'(r_idx) != (r_len - LW'(1)));
                end
                if (move) begin
                    em_we   = 1'b1;
                    n_ovld  = 1'b1;
                    n_oel   = em_data;
                    n_olast = r_tlast;
                    n_ostat = npe_pkg::STATUS_OK;
                    if (r_tlast) begin
                        n_bank  = !r_bank;
                        n_state = S_IDLE;
                    end
                end
            end

            S_NONE: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_oel   = '0;
                    n_olast = 1'b1;
                    n_ostat = npe_pkg::STATUS_NONE;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Loads go to the active bank, the new permutation to the other one.
    assign we0    = (ld_we && !r_bank) || (em_we && r_bank);
    assign we1    = (ld_we && r_bank) || (em_we && !r_bank);
    assign waddr0 = r_bank ? r_raddr : ld_addr;
    assign waddr1 = r_bank ? ld_addr : r_raddr;
    assign wdata0 = r_bank ? em_data : i_value;
    assign wdata1 = r_bank ? i_value : em_data;

    npe_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LEN)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr0),
        .i_wdata (wdata0),
        .i_re    (rd_en && !r_bank),
        .i_raddr (rd_addr),
        .o_rdata (rd0)
    );

    npe_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LEN)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr1),
        .i_wdata (wdata1),
        .i_re    (rd_en && r_bank),
        .i_raddr (rd_addr),
        .o_rdata (rd1)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_closed <= 1'b0;
            r_bank   <= 1'b0;
            r_rv     <= 1'b0;
            r_go     <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_closed <= n_closed;
            r_bank   <= n_bank;
            r_rv     <= n_rv;
            r_go     <= n_go;
            r_ovld   <= n_ovld;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_raddr <= n_raddr;
        r_prev  <= n_prev;
        r_hprev <= n_hprev;
        r_piv   <= n_piv;
        r_pval  <= n_pval;
        r_qidx  <= n_qidx;
        r_qval  <= n_qval;
        r_tsrc  <= n_tsrc;
        r_tlast <= n_tlast;
        r_oel   <= n_oel;
        r_olast <= n_olast;
        r_ostat <= n_ostat;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_element   = r_oel;
    assign o_last      = r_olast;
    assign o_status    = r_ostat;

    // The held length never exceeds the capacity.
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_LEN))
        else $error("sequence length exceeds capacity");

    // A pending scan read always lies inside the sequence.
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PIV) || (r_state == S_SUCC)) && r_rv |-> LW'(r_raddr) < r_len)
        else $error("scan read outside the sequence");

    // A pending output beat addresses an element of the sequence.
    a_emit_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && r_rv |-> LW'(r_raddr) < r_len)
        else $error("emit beat outside the sequence");

    // A no-next beat is always the last of its advance.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && (r_ostat == npe_pkg::STATUS_NONE) |-> r_olast)
        else $error("no-next beat without last");

    // The banks swap only when an emit pass finishes.
    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_bank) |-> $past(r_state == S_EMIT) && (r_state == S_IDLE))
        else $error("bank swap outside an emit pass");

endmodule
